### design/wheel_speed_incremental_pid_core_assert.svh
// ----------------------------------------------------------------------------
// Wheel speed PID core assertion macros
// Concurrent check macros, clocked on aclk and disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef WHEEL_SPEED_INCREMENTAL_PID_CORE_ASSERT_SVH
`define WHEEL_SPEED_INCREMENTAL_PID_CORE_ASSERT_SVH

// The condition holds at every clock edge outside reset.
`define WSPID_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("wspid invariant check failed");

// The consequent holds in the same cycle as the antecedent.
`define WSPID_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("wspid same-cycle check failed");

// The consequent holds in the cycle after the antecedent.
`define WSPID_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("wspid next-cycle check failed");

`endif

### design/wspid_pkg.sv
// ----------------------------------------------------------------------------
// Wheel speed PID package
// Widths, constants, register indexes and shared types of the speed loop.
// ----------------------------------------------------------------------------
package wspid_pkg;

    localparam int COUNT_WIDTH    = 16;
    localparam int GAIN_FRAC_BITS = 8;

    localparam int GAIN_W   = 16;
    localparam int SPEED_W  = 18;
    localparam int SMOOTH_W = 17;
    localparam int ERR_W    = 19;
    localparam int DE_W     = 20;
    localparam int D2E_W    = 21;
    localparam int PROD_W   = GAIN_W + 1 + D2E_W;
    localparam int SUM_W    = PROD_W + 2;
    localparam int DUTY_W   = 10;
    localparam int ACC_W    = DUTY_W + GAIN_FRAC_BITS;
    localparam int TGT_W    = 11;
    localparam int SLEW_W   = 11;

    localparam int COUNT_CAP = 2000;
    localparam int BASE_DUTY = 300;
    localparam int DUTY_CAP  = 950;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_SPEED    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_GAIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DERIVATIVE_GAIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_LIMIT      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SLEW_STEP       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_OFFSET     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_OFFSET    = 3'd7;

    typedef struct packed {
        logic [TGT_W-1:0]  target_speed;
        logic [GAIN_W-1:0] prop_gain;
        logic [GAIN_W-1:0] integral_gain;
        logic [GAIN_W-1:0] derivative_gain;
        logic [DUTY_W-1:0] duty_limit;
        logic [SLEW_W-1:0] slew_step;
        logic [DUTY_W-1:0] left_offset;
        logic [DUTY_W-1:0] right_offset;
    } cfg_t;

    typedef struct packed {
        logic signed [ERR_W-1:0] err;
        logic signed [DE_W-1:0]  de;
        logic signed [D2E_W-1:0] d2e;
        logic [SMOOTH_W-1:0]     speed;
    } fq_entry_t;

    typedef struct packed {
        logic               push;
        logic               pop;
        logic [FIFO_CW-1:0] count;
    } fifo_stat_t;

endpackage

### design/wspid_fifo.sv
// ----------------------------------------------------------------------------
// Wheel speed PID queue
// Short queue that parts the error front end from the PID back end.
// ----------------------------------------------------------------------------
module wspid_fifo import wspid_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push_valid,
    output logic       push_ready,
    input  fq_entry_t  push_data,
    output logic       pop_valid,
    input  logic       pop_ready,
    output fq_entry_t  pop_data,
    output fifo_stat_t stat
);

    fq_entry_t          mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_CW-1:0] count_reg;
    logic [FIFO_AW-1:0] wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_next;
    logic               push;
    logic               pop;

    assign push_ready = (count_reg != FIFO_CW'(FIFO_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    assign wr_ptr_next = (wr_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    assign stat.push  = push;
    assign stat.pop   = pop;
    assign stat.count = count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_next;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### design/wspid_front.sv
// ----------------------------------------------------------------------------
// Wheel speed PID front end
// Caps and sums the encoder counts, slew limits the speed and forms the
// error and its first and second differences.
// ----------------------------------------------------------------------------
module wspid_front import wspid_pkg::*; (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  cfg_t                          cfg,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic signed [COUNT_WIDTH-1:0] left_pulses,
    input  logic signed [COUNT_WIDTH-1:0] right_pulses,
    output logic                          push_valid,
    input  logic                          push_ready,
    output fq_entry_t                     push_data
);

    localparam logic signed [SPEED_W-1:0] CAP_S = SPEED_W'(COUNT_CAP);

    logic                      s1_valid_reg;
    logic signed [SPEED_W-1:0] s1_speed_reg;
    logic signed [SPEED_W-1:0] filt_reg;
    logic                      s2_valid_reg;
    fq_entry_t                 s2_data_reg;
    logic signed [ERR_W-1:0]   err_last_reg;
    logic signed [ERR_W-1:0]   err_prev_reg;

    logic signed [SPEED_W-1:0] left_ext;
    logic signed [SPEED_W-1:0] right_ext;
    logic signed [SPEED_W-1:0] left_cap;
    logic signed [SPEED_W-1:0] right_cap;
    logic signed [SPEED_W-1:0] raw_speed;
    logic signed [SPEED_W:0]   diff;
    logic signed [SPEED_W:0]   step2;
    logic signed [SPEED_W-1:0] filt_next;
    logic signed [ERR_W-1:0]   err_next;
    fq_entry_t                 s2_data_next;
    logic                      s1_load;
    logic                      s2_load;
    logic                      s2_ready;

    assign s2_ready = !s2_valid_reg || push_ready;
    assign s_tready = !s1_valid_reg || s2_ready;
    assign s1_load  = s_tvalid && s_tready;
    assign s2_load  = s1_valid_reg && s2_ready;

    assign push_valid = s2_valid_reg;
    assign push_data  = s2_data_reg;

    always_comb begin
        left_ext  = {{(SPEED_W - COUNT_WIDTH){left_pulses[COUNT_WIDTH-1]}}, left_pulses};
        right_ext = {{(SPEED_W - COUNT_WIDTH){right_pulses[COUNT_WIDTH-1]}}, right_pulses};
        left_cap  = (left_ext > CAP_S) ? CAP_S : left_ext;
        right_cap = (right_ext > CAP_S) ? CAP_S : right_ext;
        raw_speed = left_cap + right_cap;
        diff      = {raw_speed[SPEED_W-1], raw_speed} - {filt_reg[SPEED_W-1], filt_reg};
        step2     = $signed({{(SPEED_W - SLEW_W){1'b0}}, cfg.slew_step, 1'b0});
        if (!diff[SPEED_W] && (diff > step2)) begin
            filt_next = filt_reg + step2[SPEED_W-1:0];
        end else if (diff[SPEED_W] && (diff < -step2)) begin
            filt_next = filt_reg - step2[SPEED_W-1:0];
        end else begin
            filt_next = raw_speed;
        end
    end

    always_comb begin
        err_next = $signed({{(ERR_W - TGT_W - 1){1'b0}}, cfg.target_speed, 1'b0})
                 - {{(ERR_W - SPEED_W){s1_speed_reg[SPEED_W-1]}}, s1_speed_reg};
        s2_data_next.err = err_next;
        s2_data_next.de  = {err_next[ERR_W-1], err_next}
                         - {err_last_reg[ERR_W-1], err_last_reg};
        s2_data_next.d2e = {{2{err_next[ERR_W-1]}}, err_next}
                         - {err_last_reg[ERR_W-1], err_last_reg, 1'b0}
                         + {{2{err_prev_reg[ERR_W-1]}}, err_prev_reg};
        s2_data_next.speed = s1_speed_reg[SMOOTH_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            filt_reg     <= '0;
            err_last_reg <= '0;
            err_prev_reg <= '0;
        end else begin
            if (s1_load) begin
                s1_valid_reg <= 1'b1;
                filt_reg     <= filt_next;
            end else if (s2_load) begin
                s1_valid_reg <= 1'b0;
            end
            if (s2_load) begin
                s2_valid_reg <= 1'b1;
                err_last_reg <= err_next;
                err_prev_reg <= err_last_reg;
            end else if (push_ready) begin
                s2_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_load) begin
            s1_speed_reg <= filt_next;
        end
        if (s2_load) begin
            s2_data_reg <= s2_data_next;
        end
    end

endmodule

### design/wspid_back.sv
// ----------------------------------------------------------------------------
// Wheel speed PID back end
// Multiplies the error terms by the gains, accumulates the clamped duty and
// forms the two saturated wheel duties in the output register.
// ----------------------------------------------------------------------------
module wspid_back import wspid_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  cfg_t                cfg,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  fq_entry_t           pop_data,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [DUTY_W-1:0]   left_duty,
    output logic [DUTY_W-1:0]   right_duty,
    output logic [SMOOTH_W-1:0] smoothed_speed,
    output logic [DUTY_W-1:0]   speed_duty
);

    localparam int WD_W = DUTY_W + 2;

    logic                      m3_valid_reg;
    logic signed [PROD_W-1:0]  pp_reg;
    logic signed [PROD_W-1:0]  pi_reg;
    logic signed [PROD_W-1:0]  pd_reg;
    logic [SMOOTH_W-1:0]       m3_speed_reg;
    logic                      m4_valid_reg;
    logic [ACC_W-1:0]          acc_reg;
    logic [SMOOTH_W-1:0]       m4_speed_reg;
    logic                      m5_valid_reg;
    logic [DUTY_W-1:0]         ld_reg;
    logic [DUTY_W-1:0]         rd_reg;
    logic [SMOOTH_W-1:0]       m5_speed_reg;
    logic [DUTY_W-1:0]         m5_duty_reg;

    logic signed [D2E_W-1:0]   err_x;
    logic signed [D2E_W-1:0]   de_x;
    logic signed [PROD_W-1:0]  pp_next;
    logic signed [PROD_W-1:0]  pi_next;
    logic signed [PROD_W-1:0]  pd_next;
    logic signed [SUM_W-1:0]   delta;
    logic signed [SUM_W-1:0]   acc_sum;
    logic signed [SUM_W-1:0]   top;
    logic [ACC_W-1:0]          acc_next;
    logic [DUTY_W-1:0]         duty;
    logic [WD_W-1:0]           ld_sum;
    logic [WD_W-1:0]           rd_sum;
    logic [DUTY_W-1:0]         ld_next;
    logic [DUTY_W-1:0]         rd_next;
    logic                      s3_ready;
    logic                      s4_ready;
    logic                      s5_ready;
    logic                      l3;
    logic                      l4;
    logic                      l5;

    assign s5_ready  = !m5_valid_reg || m_tready;
    assign s4_ready  = !m4_valid_reg || s5_ready;
    assign s3_ready  = !m3_valid_reg || s4_ready;
    assign pop_ready = s3_ready;
    assign l3        = pop_valid && s3_ready;
    assign l4        = m3_valid_reg && s4_ready;
    assign l5        = m4_valid_reg && s5_ready;

    always_comb begin
        err_x   = {{(D2E_W - ERR_W){pop_data.err[ERR_W-1]}}, pop_data.err};
        de_x    = {{(D2E_W - DE_W){pop_data.de[DE_W-1]}}, pop_data.de};
        pp_next = $signed({1'b0, cfg.prop_gain}) * de_x;
        pi_next = $signed({1'b0, cfg.integral_gain}) * err_x;
        pd_next = $signed({1'b0, cfg.derivative_gain}) * pop_data.d2e;
    end

    always_comb begin
        delta   = SUM_W'(pp_reg) + SUM_W'(pi_reg) + SUM_W'(pd_reg);
        acc_sum = $signed({{(SUM_W - ACC_W){1'b0}}, acc_reg}) + (delta >>> 1);
        top     = $signed({{(SUM_W - ACC_W){1'b0}}, cfg.duty_limit, {GAIN_FRAC_BITS{1'b0}}});
        if (acc_sum > top) begin
            acc_next = top[ACC_W-1:0];
        end else if (acc_sum[SUM_W-1]) begin
            acc_next = '0;
        end else begin
            acc_next = acc_sum[ACC_W-1:0];
        end
    end

    always_comb begin
        duty    = acc_reg[ACC_W-1:GAIN_FRAC_BITS];
        ld_sum  = WD_W'(BASE_DUTY) + WD_W'(duty) + WD_W'(cfg.left_offset);
        rd_sum  = WD_W'(BASE_DUTY) + WD_W'(duty) + WD_W'(cfg.right_offset);
        ld_next = (ld_sum > WD_W'(DUTY_CAP)) ? DUTY_W'(DUTY_CAP) : ld_sum[DUTY_W-1:0];
        rd_next = (rd_sum > WD_W'(DUTY_CAP)) ? DUTY_W'(DUTY_CAP) : rd_sum[DUTY_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m3_valid_reg <= 1'b0;
            m4_valid_reg <= 1'b0;
            m5_valid_reg <= 1'b0;
            acc_reg      <= '0;
        end else begin
            if (l3) begin
                m3_valid_reg <= 1'b1;
            end else if (s4_ready) begin
                m3_valid_reg <= 1'b0;
            end
            if (l4) begin
                m4_valid_reg <= 1'b1;
                acc_reg      <= acc_next;
            end else if (s5_ready) begin
                m4_valid_reg <= 1'b0;
            end
            if (l5) begin
                m5_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m5_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (l3) begin
            pp_reg       <= pp_next;
            pi_reg       <= pi_next;
            pd_reg       <= pd_next;
            m3_speed_reg <= pop_data.speed;
        end
        if (l4) begin
            m4_speed_reg <= m3_speed_reg;
        end
        if (l5) begin
            ld_reg       <= ld_next;
            rd_reg       <= rd_next;
            m5_speed_reg <= m4_speed_reg;
            m5_duty_reg  <= duty;
        end
    end

    assign m_tvalid       = m5_valid_reg;
    assign left_duty      = ld_reg;
    assign right_duty     = rd_reg;
    assign smoothed_speed = m5_speed_reg;
    assign speed_duty     = m5_duty_reg;

endmodule

### design/wheel_speed_incremental_pid_core.sv
// Path: an accepted beat moves through s1, s2, the queue, m3, m4 and m5 to m_tvalid.
// Throughput: one beat per cycle unless m_tready stalls; each state recurrence
// (slew filter, error history, duty accumulator) closes within one register stage.
// Reset: aresetn low clears all loop state, empties the queue and restores the
// register defaults; no clearing pass follows.
// ----------------------------------------------------------------------------
// Wheel speed incremental PID core
// Turns two encoder counts per control tick into two motor PWM duties.
// ----------------------------------------------------------------------------
module wheel_speed_incremental_pid_core import wspid_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // left_pulses [15:0], right_pulses [31:16]
    input  logic [31:0]           s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // left_duty [9:0], right_duty [19:10], smoothed_speed [36:20],
    // speed_duty [46:37], zero [47]
    output logic [47:0]           m_tdata
);

    cfg_t                cfg_reg;
    logic                fq_push_valid;
    logic                fq_push_ready;
    fq_entry_t           fq_push_data;
    logic                fq_pop_valid;
    logic                fq_pop_ready;
    fq_entry_t           fq_pop_data;
    fifo_stat_t          fq_stat;
    logic [DUTY_W-1:0]   left_duty;
    logic [DUTY_W-1:0]   right_duty;
    logic [SMOOTH_W-1:0] smoothed_speed;
    logic [DUTY_W-1:0]   speed_duty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.target_speed    <= TGT_W'(500);
            cfg_reg.prop_gain       <= GAIN_W'(12800);
            cfg_reg.integral_gain   <= '0;
            cfg_reg.derivative_gain <= '0;
            cfg_reg.duty_limit      <= DUTY_W'(1000);
            cfg_reg.slew_step       <= SLEW_W'(300);
            cfg_reg.left_offset     <= '0;
            cfg_reg.right_offset    <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_TARGET_SPEED: begin
                    cfg_reg.target_speed <= cfg_wdata[TGT_W-1:0];
                end
                REG_PROP_GAIN: begin
                    cfg_reg.prop_gain <= cfg_wdata[GAIN_W-1:0];
                end
                REG_INTEGRAL_GAIN: begin
                    cfg_reg.integral_gain <= cfg_wdata[GAIN_W-1:0];
                end
                REG_DERIVATIVE_GAIN: begin
                    cfg_reg.derivative_gain <= cfg_wdata[GAIN_W-1:0];
                end
                REG_DUTY_LIMIT: begin
                    cfg_reg.duty_limit <= cfg_wdata[DUTY_W-1:0];
                end
                REG_SLEW_STEP: begin
                    cfg_reg.slew_step <= cfg_wdata[SLEW_W-1:0];
                end
                REG_LEFT_OFFSET: begin
                    cfg_reg.left_offset <= cfg_wdata[DUTY_W-1:0];
                end
                REG_RIGHT_OFFSET: begin
                    cfg_reg.right_offset <= cfg_wdata[DUTY_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    wspid_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .left_pulses  (s_tdata[15:0]),
        .right_pulses (s_tdata[31:16]),
        .push_valid   (fq_push_valid),
        .push_ready   (fq_push_ready),
        .push_data    (fq_push_data)
    );

    wspid_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fq_push_valid),
        .push_ready (fq_push_ready),
        .push_data  (fq_push_data),
        .pop_valid  (fq_pop_valid),
        .pop_ready  (fq_pop_ready),
        .pop_data   (fq_pop_data),
        .stat       (fq_stat)
    );

    wspid_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .pop_valid      (fq_pop_valid),
        .pop_ready      (fq_pop_ready),
        .pop_data       (fq_pop_data),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .left_duty      (left_duty),
        .right_duty     (right_duty),
        .smoothed_speed (smoothed_speed),
        .speed_duty     (speed_duty)
    );

    assign m_tdata = {1'b0, speed_duty, smoothed_speed, right_duty, left_duty};

`include "wheel_speed_incremental_pid_core_assert.svh"

    `WSPID_ASSERT_ALWAYS(a_fifo_bound, fq_stat.count <= FIFO_CW'(FIFO_DEPTH))
    `WSPID_ASSERT_IMPL(a_duty_range, m_tvalid, (left_duty >= DUTY_W'(BASE_DUTY)) && (left_duty <= DUTY_W'(DUTY_CAP)) && (right_duty >= DUTY_W'(BASE_DUTY)) && (right_duty <= DUTY_W'(DUTY_CAP)))
    `WSPID_ASSERT_IMPL(a_duty_floor, m_tvalid, (left_duty == DUTY_W'(DUTY_CAP)) || ((DUTY_W + 1)'(left_duty) >= (DUTY_W + 1)'(speed_duty) + (DUTY_W + 1)'(BASE_DUTY)))
    `WSPID_ASSERT_NEXT(a_fifo_fill, fq_stat.push && !fq_stat.pop, fq_stat.count == $past(fq_stat.count) + FIFO_CW'(1))

endmodule

### tb/wheel_speed_incremental_pid_core_tb.sv
// ----------------------------------------------------------------------------
// Wheel speed incremental PID core testbench
// Drives encoder count beats through the speed loop under random stalls on
// both sides and checks every duty beat against a cycle-free model of the
// slew filter, the incremental PID and the duty clamps, across several
// register settings that include the range extremes.
// ----------------------------------------------------------------------------
module wheel_speed_incremental_pid_core_tb;
    import wspid_pkg::*;

    localparam int NUM_REGS         = 8;
    localparam int RANDOM_PHASES    = 8;
    localparam int TICKS_PER_PHASE  = 240;
    localparam int SETTLE_CYCLES    = 10;
    localparam int LONG_HOLD_CYCLES = 80;
    localparam int CYCLE_LIMIT      = 500000;
    localparam int MAX_REPORTS      = 200;

    typedef struct packed {
        logic [DUTY_W-1:0]          speed_duty;
        logic signed [SMOOTH_W-1:0] smoothed_speed;
        logic [DUTY_W-1:0]          right_duty;
        logic [DUTY_W-1:0]          left_duty;
    } duty_beat_t;

    class speed_loop_scoreboard;
        cfg_t       cfg;
        longint     filt_speed, err_last, err_prev, duty_acc;
        duty_beat_t duty_q[$];
        int         errors;

        function new();
            cfg.target_speed    = 500;
            cfg.prop_gain       = 12800;
            cfg.integral_gain   = 0;
            cfg.derivative_gain = 0;
            cfg.duty_limit      = 1000;
            cfg.slew_step       = 300;
            cfg.left_offset     = 0;
            cfg.right_offset    = 0;
            filt_speed = 0;
            err_last   = 0;
            err_prev   = 0;
            duty_acc   = 0;
            errors     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_TARGET_SPEED:    cfg.target_speed    = val[TGT_W-1:0];
                REG_PROP_GAIN:       cfg.prop_gain       = val[GAIN_W-1:0];
                REG_INTEGRAL_GAIN:   cfg.integral_gain   = val[GAIN_W-1:0];
                REG_DERIVATIVE_GAIN: cfg.derivative_gain = val[GAIN_W-1:0];
                REG_DUTY_LIMIT:      cfg.duty_limit      = val[DUTY_W-1:0];
                REG_SLEW_STEP:       cfg.slew_step       = val[SLEW_W-1:0];
                REG_LEFT_OFFSET:     cfg.left_offset     = val[DUTY_W-1:0];
                REG_RIGHT_OFFSET:    cfg.right_offset    = val[DUTY_W-1:0];
                default: ;
            endcase
        endfunction

        function int outstanding();
            return duty_q.size();
        endfunction

        function void note_tick(logic [31:0] tdata);
            logic signed [15:0] left_raw, right_raw;
            longint left, right, speed, step2, err, de, d2e, delta, top, duty, ld, rd;
            longint tgt, kp, ki, kd, lim, lo, ro;
            duty_beat_t want;
            left_raw  = tdata[15:0];
            right_raw = tdata[31:16];
            left  = left_raw;
            right = right_raw;
            tgt = cfg.target_speed;
            kp  = cfg.prop_gain;
            ki  = cfg.integral_gain;
            kd  = cfg.derivative_gain;
            lim = cfg.duty_limit;
            lo  = cfg.left_offset;
            ro  = cfg.right_offset;
            step2 = cfg.slew_step;
            step2 = 2 * step2;

            if (left > COUNT_CAP) left = COUNT_CAP;
            if (right > COUNT_CAP) right = COUNT_CAP;
            speed = left + right;
            if (speed - filt_speed > step2) speed = filt_speed + step2;
            else if (speed - filt_speed < -step2) speed = filt_speed - step2;
            filt_speed = speed;

            err   = 2 * tgt - filt_speed;
            de    = err - err_last;
            d2e   = err - 2 * err_last + err_prev;
            delta = kp * de + ki * err + kd * d2e;
            duty_acc = duty_acc + (delta >>> 1);
            top = lim << GAIN_FRAC_BITS;
            if (duty_acc > top) duty_acc = top;
            if (duty_acc < 0) duty_acc = 0;
            err_prev = err_last;
            err_last = err;

            duty = duty_acc >>> GAIN_FRAC_BITS;
            ld = BASE_DUTY + duty + lo;
            rd = BASE_DUTY + duty + ro;
            if (ld > DUTY_CAP) ld = DUTY_CAP;
            if (rd > DUTY_CAP) rd = DUTY_CAP;

            want.left_duty      = DUTY_W'(ld);
            want.right_duty     = DUTY_W'(rd);
            want.smoothed_speed = SMOOTH_W'(filt_speed);
            want.speed_duty     = DUTY_W'(duty);
            duty_q.push_back(want);
        endfunction

        function void compare(string field, longint want, longint got);
            if (want != got) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: %s mismatch, expected %0d, actual %0d",
                             $time, field, want, got);
            end
        endfunction

        function void check_duties(logic [47:0] tdata);
            duty_beat_t got, want;
            got = tdata[46:0];
            if (duty_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected duty beat, expected none, actual %h",
                             $time, tdata);
                return;
            end
            want = duty_q.pop_front();
            compare("left_duty", want.left_duty, got.left_duty);
            compare("right_duty", want.right_duty, got.right_duty);
            compare("smoothed_speed", want.smoothed_speed, got.smoothed_speed);
            compare("speed_duty", want.speed_duty, got.speed_duty);
            compare("padding", 0, tdata[47]);
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [31:0]           s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [47:0]           m_tdata;

    speed_loop_scoreboard sb = new();
    logic [CFG_DATA_W-1:0] settings [NUM_REGS];
    int unsigned reg_high [NUM_REGS] = '{2000, 65535, 65535, 65535, 1000, 2000, 650, 650};
    int unsigned reg_mask [NUM_REGS] = '{2047, 65535, 65535, 65535, 1023, 2047, 1023, 1023};
    bit tx_idling = 1'b0;
    bit rx_idling = 1'b0;
    bit long_hold = 1'b0;
    int cycle_count = 0;

    wheel_speed_incremental_pid_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_tick(s_tdata);
            if (m_tvalid && m_tready) sb.check_duties(m_tdata);
        end
    end

    initial begin
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (long_hold) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge aclk);
                long_hold = 1'b0;
            end else if (rx_idling && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    task automatic send_tick(input logic [15:0] left, input logic [15:0] right);
        if (tx_idling && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {right, left};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain(input int settle);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic program_loop();
        cfg_we <= 1'b1;
        for (int i = 0; i < NUM_REGS; i++) begin
            cfg_index <= CFG_IDX_W'(i);
            cfg_wdata <= settings[i];
            @(posedge aclk);
            sb.write_reg(CFG_IDX_W'(i), settings[i]);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic pick_settings();
        for (int i = 0; i < NUM_REGS; i++) begin
            case ($urandom_range(0, 6))
                0: settings[i] = '0;
                1: settings[i] = CFG_DATA_W'(reg_mask[i]);
                2: settings[i] = CFG_DATA_W'(reg_high[i]);
                3: settings[i] = CFG_DATA_W'($urandom);
                default: settings[i] = CFG_DATA_W'($urandom_range(0, reg_high[i]));
            endcase
        end
        if ($urandom_range(0, 2) != 0) begin
            settings[REG_PROP_GAIN] = CFG_DATA_W'($urandom_range(0, 4096));
        end
        if ($urandom_range(0, 2) != 0) begin
            settings[REG_INTEGRAL_GAIN] = CFG_DATA_W'($urandom_range(0, 512));
        end
        if ($urandom_range(0, 2) != 0) begin
            settings[REG_DERIVATIVE_GAIN] = CFG_DATA_W'($urandom_range(0, 1024));
        end
    endtask

    function automatic logic [15:0] random_count();
        case ($urandom_range(0, 9))
            0, 1: return 16'($urandom);
            2: return 16'(-int'($urandom_range(1, 600)));
            3: return 16'($urandom_range(1900, 2100));
            default: return 16'($urandom_range(0, 2100));
        endcase
    endfunction

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_tick(16'd0, 16'd0);
        send_tick(16'd2000, 16'd2000);
        send_tick(16'd2001, 16'd2001);
        send_tick(16'h7FFF, 16'h7FFF);
        send_tick(16'h8000, 16'h8000);
        send_tick(16'hFFFF, 16'h0001);
        send_tick(16'h7FFF, 16'h8000);
        send_tick(16'd600, 16'd400);
        drain(SETTLE_CYCLES);

        settings[REG_TARGET_SPEED]    = 16'hFFFF;
        settings[REG_PROP_GAIN]       = 16'hFFFF;
        settings[REG_INTEGRAL_GAIN]   = 16'hFFFF;
        settings[REG_DERIVATIVE_GAIN] = 16'hFFFF;
        settings[REG_DUTY_LIMIT]      = 16'd1023;
        settings[REG_SLEW_STEP]       = 16'd2047;
        settings[REG_LEFT_OFFSET]     = 16'd1023;
        settings[REG_RIGHT_OFFSET]    = 16'd650;
        program_loop();
        send_tick(16'd2000, 16'd2000);
        send_tick(16'd0, 16'd0);
        send_tick(16'h8000, 16'h8000);
        send_tick(16'h7FFF, 16'h7FFF);
        send_tick(16'h5555, 16'hAAAA);
        send_tick(16'hAAAA, 16'h5555);
        send_tick(16'd1000, 16'd1000);
        send_tick(16'd1000, 16'd0);
        drain(SETTLE_CYCLES);

        settings[REG_TARGET_SPEED]    = 16'd0;
        settings[REG_PROP_GAIN]       = 16'd256;
        settings[REG_INTEGRAL_GAIN]   = 16'd0;
        settings[REG_DERIVATIVE_GAIN] = 16'd0;
        settings[REG_DUTY_LIMIT]      = 16'd0;
        settings[REG_SLEW_STEP]       = 16'd0;
        settings[REG_LEFT_OFFSET]     = 16'd0;
        settings[REG_RIGHT_OFFSET]    = 16'd0;
        program_loop();
        send_tick(16'h7FFF, 16'h7FFF);
        send_tick(16'h8000, 16'h8000);
        send_tick(16'h1234, 16'h4321);
        send_tick(16'd0, 16'd0);
        drain(SETTLE_CYCLES);

        settings[REG_TARGET_SPEED]    = 16'd1000;
        settings[REG_PROP_GAIN]       = 16'd2560;
        settings[REG_INTEGRAL_GAIN]   = 16'd128;
        settings[REG_DERIVATIVE_GAIN] = 16'd64;
        settings[REG_DUTY_LIMIT]      = 16'd700;
        settings[REG_SLEW_STEP]       = 16'd50;
        settings[REG_LEFT_OFFSET]     = 16'd100;
        settings[REG_RIGHT_OFFSET]    = 16'd650;
        program_loop();
        send_tick(16'd900, 16'd1100);
        send_tick(16'd1000, 16'd1000);
        send_tick(16'd1500, 16'd500);
        send_tick(16'd0, 16'd2000);
        send_tick(16'd2100, 16'd1900);
        drain(SETTLE_CYCLES);

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            pick_settings();
            program_loop();
            tx_idling = (phase != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
            rx_idling = (phase != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
            for (int n = 0; n < TICKS_PER_PHASE; n++) begin
                if (phase == 1 && n == 60) long_hold = 1'b1;
                if (phase == 3 && n == 120) drain(0);
                send_tick(random_count(), random_count());
            end
            drain(SETTLE_CYCLES);
        end

        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
